FILE: hw/rtl/bb3_pkg.sv
// Shared constants, types and helper functions for the 3x3 box blur block.
// Used by every module of the block; depends on nothing else.

package bb3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIXEL_W    = 8;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
   localparam int IN_ROW_W   = $clog2(MAX_HEIGHT + 2);
   localparam int OUT_ROW_W  = $clog2(MAX_HEIGHT);
   localparam int LINE_W     = 2 * PIXEL_W;

   // Register field widths and the configuration port.
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(1024);
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(768);

   // Mean arithmetic: sum of up to nine pixels, divided by a reciprocal multiply.
   localparam int SUM_W       = PIXEL_W + 4;
   localparam int COUNT_W     = 4;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // One item as it enters the line memory stage.
   typedef struct packed {
      logic [COL_W-1:0]   column;
      logic [PIXEL_W-1:0] pixel;
      logic               have;
      logic               last;
      logic [2:0]         col_mask;
      logic [2:0]         row_mask;
      logic [COUNT_W-1:0] count;
   } s1_item_type;

   // One result on its way to the divider.
   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
      logic               last;
   } s2_item_type;

   // Number of taps selected by a column mask and a row mask.
   function automatic logic [COUNT_W-1:0] tap_count(input logic [2:0] cols,
                                                    input logic [2:0] rows);
      logic [1:0] ncol;
      logic [1:0] nrow;
      logic [3:0] product;
      ncol    = 2'(cols[0]) + 2'(cols[1]) + 2'(cols[2]);
      nrow    = 2'(rows[0]) + 2'(rows[1]) + 2'(rows[2]);
      product = {2'b00, ncol} * {2'b00, nrow};
      return COUNT_W'(product);
   endfunction

   // ceil(2^16 / count); exact floor for every sum below 2^15.
   function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
      logic [RECIP_W-1:0] value;
      case (count)
         4'd1:    value = RECIP_W'(65536);
         4'd2:    value = RECIP_W'(32768);
         4'd3:    value = RECIP_W'(21846);
         4'd4:    value = RECIP_W'(16384);
         4'd6:    value = RECIP_W'(10923);
         4'd9:    value = RECIP_W'(7282);
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

FILE: hw/rtl/box_blur_3x3_border_clipped_top.sv
// 3x3 box blur, border clipped: top level with registers and raster position.
// Depends on bb3_pkg, bb3_window and bb3_divide.
//
// Pixels arrive in raster order on the req_ channel, one per transaction; a
// transaction is taken when req_valid is high and req_stall is low. After a
// frame the source sends image_width + 1 drain transactions (req_operation
// set). Each pixel's floored mean over its in-frame 3x3 neighborhood leaves on
// the rsp_ channel with the transaction of item m + image_width + 1; rsp_last
// marks the final pixel of the frame, and the next item starts a new frame.
// The result of a triggering item is registered after the line memory read,
// again as the sum, and once more after the reciprocal multiply.
// Throughput: one item per cycle; each item does one read and one write of the
// line memory, an array of MAX_WIDTH entries that each hold two rows.
// A stalled result is held in the output register; the pipeline behind it
// fills and then req_stall rises until the receiver takes the result.
// Reset clears the position, empties the pipeline and loads width 1024,
// height 768. Registers (csr_index 0 width, 1 height) are always ready; the
// user must write them only while no result is outstanding; not enforced.

module box_blur_3x3_border_clipped_top
   import bb3_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [PIXEL_W-1:0]     req_pixel_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_pixel_out,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [CFG_WIDTH_W-1:0]  width_ff, width_in;
   logic [CFG_HEIGHT_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]        in_col_ff, in_col_in;
   logic [IN_ROW_W-1:0]     in_row_ff, in_row_in;

   logic [WIDTH_W-1:0]      w_eff;
   logic [HEIGHT_W-1:0]     h_eff;
   logic                    restart;
   logic [COL_W-1:0]        ci;
   logic [IN_ROW_W-1:0]     ri;
   logic                    have;
   logic [COL_W-1:0]        out_col;
   logic [OUT_ROW_W-1:0]    out_row;
   logic                    is_last;
   logic [WIDTH_W:0]        col_next;
   logic                    accept;
   logic                    s1_ready;
   logic                    s2_free;
   logic                    s2_load;
   s1_item_type             item;
   s2_item_type             s2_data;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign req_stall = !s1_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[CFG_HEIGHT_W-1:0];
            default:          ;
         endcase
      end
   end

   // Register values of zero act as one; larger ones saturate at the maximum.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = WIDTH_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = HEIGHT_W'(height_ff);
      end
   end

   // Position of the arriving item. A position outside the frame plus its drain
   // row (possible after a register change) restarts the frame.
   always_comb begin
      logic [IN_ROW_W:0] h_plus1;
      h_plus1 = (IN_ROW_W+1)'(h_eff) + (IN_ROW_W+1)'(1);
      restart = ((WIDTH_W+1)'(in_col_ff) >= (WIDTH_W+1)'(w_eff))
             || ((IN_ROW_W+1)'(in_row_ff) > h_plus1)
             || (((IN_ROW_W+1)'(in_row_ff) == h_plus1) && (in_col_ff != '0));
      ci = restart ? '0 : in_col_ff;
      ri = restart ? '0 : in_row_ff;
   end

   // The result centred one column back, or at the row end when this item
   // opens a new row.
   always_comb begin
      if (ci == '0) begin
         have    = (ri >= IN_ROW_W'(2));
         out_col = COL_W'(w_eff - WIDTH_W'(1));
         out_row = OUT_ROW_W'(ri - IN_ROW_W'(2));
      end else begin
         have    = (ri >= IN_ROW_W'(1));
         out_col = ci - COL_W'(1);
         out_row = OUT_ROW_W'(ri - IN_ROW_W'(1));
      end
      is_last = have
             && ((HEIGHT_W+1)'(out_row) == (HEIGHT_W+1)'(h_eff - HEIGHT_W'(1)))
             && ((WIDTH_W+1)'(out_col) == (WIDTH_W+1)'(w_eff - WIDTH_W'(1)));
   end

   always_comb begin
      item.column      = ci;
      item.pixel       = (req_operation == OP_DRAIN) ? '0 : req_pixel_in;
      item.have        = have;
      item.last        = is_last;
      item.col_mask[0] = (out_col != '0);
      item.col_mask[1] = 1'b1;
      item.col_mask[2] = ((WIDTH_W+1)'(out_col) + (WIDTH_W+1)'(1)) < (WIDTH_W+1)'(w_eff);
      item.row_mask[0] = (out_row != '0);
      item.row_mask[1] = 1'b1;
      item.row_mask[2] = ((HEIGHT_W+1)'(out_row) + (HEIGHT_W+1)'(1))
                         < (HEIGHT_W+1)'(h_eff);
      item.count       = tap_count(item.col_mask, item.row_mask);
   end

   always_comb begin
      col_next  = (WIDTH_W+1)'(ci) + (WIDTH_W+1)'(1);
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (accept) begin
         if (is_last) begin
            in_col_in = '0;
            in_row_in = '0;
         end else if (col_next >= (WIDTH_W+1)'(w_eff)) begin
            in_col_in = '0;
            in_row_in = ri + IN_ROW_W'(1);
         end else begin
            in_col_in = COL_W'(col_next);
            in_row_in = ri;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         in_col_ff <= '0;
         in_row_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
      end
   end

   bb3_window u_window (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item_in (item),
      .ready   (s1_ready),
      .s2_free (s2_free),
      .s2_load (s2_load),
      .s2_data (s2_data)
   );

   bb3_divide u_divide (
      .clock         (clock),
      .reset         (reset),
      .s2_load       (s2_load),
      .s2_data       (s2_data),
      .s2_free       (s2_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_last      (rsp_last)
   );

   // With no result held at the output the whole pipeline can advance.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> !req_stall)
      else $error("input stalled while the output register is empty");

   // The item that completes a frame returns the position to the frame start.
   assert property (@(posedge clock) disable iff (reset)
                    accept && is_last |=> (in_col_ff == '0) && (in_row_ff == '0))
      else $error("position not cleared after the last pixel of a frame");

   // The input row never runs past the final drain item's row of the largest frame.
   assert property (@(posedge clock) disable iff (reset)
                    32'(in_row_ff) <= 32'(MAX_HEIGHT + 1))
      else $error("input row counter out of range");

endmodule

FILE: hw/rtl/bb3_line_mem.sv
// Line memory: one entry per column, holding the two previous rows' pixels.
// Registered synchronous read, read-first on a same-address write.
// Depends on bb3_pkg.

module bb3_line_mem
   import bb3_pkg::*;
(
   input  logic              clock,
   input  logic              rd_en,
   input  logic [COL_W-1:0]  rd_addr,
   output logic [LINE_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [COL_W-1:0]  wr_addr,
   input  logic [LINE_W-1:0] wr_data
);

   logic [LINE_W-1:0] line_mem_ff [MAX_WIDTH];
   logic [LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bb3_window.sv
// Line memory stage: reads the column's two stored rows, shifts the 3x3 window,
// writes the column back and forms the masked neighborhood sum.
// Depends on bb3_pkg and bb3_line_mem.

module bb3_window
   import bb3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  s1_item_type item_in,
   output logic        ready,
   input  logic        s2_free,
   output logic        s2_load,
   output s2_item_type s2_data
);

   logic              s1_valid_ff, s1_valid_in;
   s1_item_type       s1_ff;
   logic              fwd_ff, fwd_in;
   logic [LINE_W-1:0] fwd_data_ff;
   logic [LINE_W-1:0] rd_data;
   logic [LINE_W-1:0] line_data;
   logic [LINE_W-1:0] wr_data;
   logic              fire;
   logic [PIXEL_W-1:0] win_ff [3][3];
   logic [PIXEL_W-1:0] win_next [3][3];
   logic [SUM_W-1:0]  sum;

   bb3_line_mem u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (item_in.column),
      .rd_data (rd_data),
      .wr_en   (fire),
      .wr_addr (s1_ff.column),
      .wr_data (wr_data)
   );

   // The previous item writes back at the same edge as this read, so a read of
   // the same column must take the written value instead of the old one.
   assign line_data = fwd_ff ? fwd_data_ff : rd_data;
   assign wr_data   = {line_data[PIXEL_W-1:0], s1_ff.pixel};

   assign fire  = s1_valid_ff && (!s1_ff.have || s2_free);
   assign ready = !s1_valid_ff || fire;
   // The forwarding choice stays with the held item until the next one is taken.
   assign fwd_in = accept ? (fire && (item_in.column == s1_ff.column)) : fwd_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_next[r][0] = win_ff[r][1];
         win_next[r][1] = win_ff[r][2];
      end
      win_next[0][2] = line_data[LINE_W-1:PIXEL_W];
      win_next[1][2] = line_data[PIXEL_W-1:0];
      win_next[2][2] = s1_ff.pixel;
   end

   // Taps outside the frame are masked off; the centre is always inside.
   always_comb begin
      logic [SUM_W-1:0] row_sum [3];
      for (int r = 0; r < 3; r++) begin
         row_sum[r] = '0;
         for (int c = 0; c < 3; c++) begin
            if (s1_ff.row_mask[r] && s1_ff.col_mask[c]) begin
               row_sum[r] = row_sum[r] + SUM_W'(win_next[r][c]);
            end
         end
      end
      sum = row_sum[0] + row_sum[1] + row_sum[2];
   end

   assign s2_load       = fire && s1_ff.have;
   assign s2_data.sum   = sum;
   assign s2_data.count = s1_ff.count;
   assign s2_data.last  = s1_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= item_in;
         fwd_data_ff <= wr_data;
      end
      if (fire) begin
         win_ff <= win_next;
      end
   end

endmodule

FILE: hw/rtl/bb3_divide.sv
// Divider and output register: multiplies the sum by the reciprocal of the tap
// count and holds the result until the receiver takes it.
// Depends on bb3_pkg.

module bb3_divide
   import bb3_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               s2_load,
   input  s2_item_type        s2_data,
   output logic               s2_free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PIXEL_W-1:0] rsp_pixel_out,
   output logic               rsp_last
);

   logic               s2_valid_ff, s2_valid_in;
   s2_item_type        s2_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff;
   logic               rsp_last_ff;
   logic               out_free;
   logic               move;
   logic [PROD_W-1:0]  product;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s2_free  = !s2_valid_ff || out_free;
   assign move     = s2_valid_ff && out_free;

   assign product = PROD_W'(s2_ff.sum) * PROD_W'(recip(s2_ff.count));

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (move) begin
         s2_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_ff <= s2_data;
      end
      if (move) begin
         rsp_pixel_ff <= product[RECIP_SHIFT +: PIXEL_W];
         rsp_last_ff  <= s2_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
